@@ rtl/segment_distance_and_reflection_top_defines.svh @@
// ----------------------------------------------------------------------------
// Segment distance and reflection: assertion macros
// Shared check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISTANCE_AND_REFLECTION_TOP_DEFINES_SVH
`define SEGMENT_DISTANCE_AND_REFLECTION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every edge outside reset
`define SDR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sdr check failed");
// Check that nxt holds in the cycle after cond
`define SDR_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("sdr check failed");
`else
`define SDR_ASSERT(lbl, clk, rstn, prop)
`define SDR_ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif

`endif

@@ rtl/sdr_pkg.sv @@
// ----------------------------------------------------------------------------
// sdr_pkg
// Types, register indexes and helpers of the segment collision kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdr_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Square root pipeline
    localparam int ROOT_STAGES = 32;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [17:0] cos_a;
        logic signed [17:0] sin_a;
        logic [30:0]        seg_len;
    } cfg_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic [30:0]        a_abs;   // along-segment offset magnitude
        logic [30:0]        b_abs;   // perpendicular offset magnitude
        logic               far;     // distance certainly saturates
        logic signed [34:0] dot;     // v.n floored to Q19.16
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } q_item_t;

    // Saturate a 40-bit signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [39:0] v);
        logic [31:0] r;
        if (!v[39] && (|v[38:31])) begin
            r = 32'h7FFF_FFFF;
        end else if (v[39] && !(&v[38:31])) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/sdr_front.sv @@
// ----------------------------------------------------------------------------
// sdr_front
// Rotates the position into the segment frame, forms v.n and classifies
// the item by region of the segment. Four stages with one shared enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_distance_and_reflection_top_defines.svh"

module sdr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdr_pkg::cfg_t        cfg_i,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_vel_x,
    input  logic signed [31:0]   s_vel_y,
    output logic                 q_push,
    input  logic                 q_ready,
    output sdr_pkg::q_item_t     q_item
);

    logic [3:0] v_reg;
    logic       en;

    // Stage 1 registers
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [31:0] vx1_reg, vy1_reg;
    logic signed [32:0] dx_next, dy_next;
    // Stage 2 registers
    logic signed [50:0] p_dxc_reg, p_dys_reg, p_dyc_reg, p_dxs_reg;
    logic signed [49:0] p_vyc_reg, p_vxs_reg;
    logic signed [31:0] vx2_reg, vy2_reg;
    // Stage 3 registers
    logic signed [35:0] px_reg, py_reg;
    logic signed [34:0] d_reg;
    logic signed [31:0] vx3_reg, vy3_reg;
    logic [51:0]        sum_px, sum_py;
    logic [50:0]        sum_d;
    // Stage 4 register
    sdr_pkg::q_item_t   item_reg, item_next;
    logic [36:0]        a_ext, a_diff, a_sel, a_abs;
    logic [35:0]        b_abs;

    // Advance the whole front unless the last item cannot enter the queue
    assign en      = !v_reg[3] || q_ready;
    assign s_ready = en;
    assign q_push  = v_reg[3] && q_ready;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], s_valid};
        end
    end

    // Offset from the segment start
    assign dx_next = {s_pos_x[31], s_pos_x} - {cfg_i.start_x[31], cfg_i.start_x};
    assign dy_next = {s_pos_y[31], s_pos_y} - {cfg_i.start_y[31], cfg_i.start_y};

    // Rotation sums, floored to Q20.16 (v.n to Q19.16)
    assign sum_px = {p_dxc_reg[50], p_dxc_reg} + {p_dys_reg[50], p_dys_reg};
    assign sum_py = {p_dyc_reg[50], p_dyc_reg} - {p_dxs_reg[50], p_dxs_reg};
    assign sum_d  = {p_vyc_reg[49], p_vyc_reg} - {p_vxs_reg[49], p_vxs_reg};

    // Classify: before start, beyond end, or alongside
    always_comb begin
        a_ext  = {px_reg[35], px_reg};
        a_diff = a_ext - {6'd0, cfg_i.seg_len};
        if (px_reg[35]) begin
            a_sel = a_ext;
        end else if (!a_diff[36] && (|a_diff)) begin
            a_sel = a_diff;
        end else begin
            a_sel = '0;
        end
        a_abs = a_sel[36] ? (37'd0 - a_sel) : a_sel;
        b_abs = py_reg[35] ? (36'd0 - py_reg) : py_reg;
        item_next.a_abs = a_abs[30:0];
        item_next.b_abs = b_abs[30:0];
        item_next.far   = (|a_abs[36:31]) || (|b_abs[35:31]);
        item_next.dot   = d_reg;
        item_next.vel_x = vx3_reg;
        item_next.vel_y = vy3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            vx1_reg   <= s_vel_x;
            vy1_reg   <= s_vel_y;
            p_dxc_reg <= dx_reg * cfg_i.cos_a;
            p_dys_reg <= dy_reg * cfg_i.sin_a;
            p_dyc_reg <= dy_reg * cfg_i.cos_a;
            p_dxs_reg <= dx_reg * cfg_i.sin_a;
            p_vyc_reg <= vy1_reg * cfg_i.cos_a;
            p_vxs_reg <= vx1_reg * cfg_i.sin_a;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            px_reg    <= sum_px[51:16];
            py_reg    <= sum_py[51:16];
            d_reg     <= sum_d[50:16];
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            item_reg  <= item_next;
        end
    end

    `SDR_ASSERT_NEXT(a_front_hold, aclk, aresetn, !en, $stable(v_reg))

endmodule

@@ rtl/sdr_fifo.sv @@
// ----------------------------------------------------------------------------
// sdr_fifo
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_distance_and_reflection_top_defines.svh"

module sdr_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sdr_pkg::q_item_t   push_item,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output sdr_pkg::q_item_t   pop_item
);

    sdr_pkg::q_item_t                mem [0:sdr_pkg::QDEPTH-1];
    logic [sdr_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [sdr_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_push, do_pop;

    assign push_ready = (count_reg != sdr_pkg::QCNT_W'(sdr_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    // Store the item at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SDR_ASSERT(a_fifo_bound, aclk, aresetn, count_reg <= sdr_pkg::QCNT_W'(sdr_pkg::QDEPTH))
    `SDR_ASSERT_NEXT(a_fifo_fill, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ rtl/sdr_back.sv @@
// ----------------------------------------------------------------------------
// sdr_back
// Squares the offsets, reflects the velocity, and takes the floor square
// root one result bit per stage. Output register at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_distance_and_reflection_top_defines.svh"

module sdr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdr_pkg::cfg_t        cfg_i,
    input  logic                 q_valid,
    input  sdr_pkg::q_item_t     q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [30:0]          m_dist_res,
    output logic signed [31:0]   m_refl_x,
    output logic signed [31:0]   m_refl_y
);

    typedef struct packed {
        logic [63:0]  n;
        logic [33:0]  rem;
        logic [31:0]  root;
        logic         far;
        logic [31:0]  rx;
        logic [31:0]  ry;
    } rt_t;

    logic               en;
    logic               b1_vld_reg;
    logic [61:0]        sq_a_reg, sq_b_reg;
    logic signed [53:0] pr_x_reg;
    logic signed [52:0] pr_y_reg;
    logic               far1_reg;
    logic signed [31:0] vx1_reg, vy1_reg;
    logic signed [18:0] nx;
    logic [62:0]        sum_sq;
    rt_t                rt0_next;

    rt_t                               rt_reg [0:sdr_pkg::ROOT_STAGES];
    logic [sdr_pkg::ROOT_STAGES:0]     rt_vld_reg;

    logic               out_vld_reg;
    logic [30:0]        dist_reg;
    logic [31:0]        rx_reg, ry_reg;

    // Advance the whole back unless the held result is not taken
    assign en      = !out_vld_reg || m_ready;
    assign q_pop   = q_valid && en;
    assign m_valid = out_vld_reg;
    assign m_dist_res = dist_reg;
    assign m_refl_x   = rx_reg;
    assign m_refl_y   = ry_reg;

    // Normal x component is the negated sine
    assign nx = 19'sd0 - {cfg_i.sin_a[17], cfg_i.sin_a};

    // Products: squares and reflection terms
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_a_reg <= q_item.a_abs * q_item.a_abs;
            sq_b_reg <= q_item.b_abs * q_item.b_abs;
            pr_x_reg <= q_item.dot * nx;
            pr_y_reg <= q_item.dot * cfg_i.cos_a;
            far1_reg <= q_item.far;
            vx1_reg  <= q_item.vel_x;
            vy1_reg  <= q_item.vel_y;
        end
    end

    // Sum of squares and reflected velocity
    always_comb begin
        sum_sq       = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};
        rt0_next.n   = {1'b0, sum_sq};
        rt0_next.rem = '0;
        rt0_next.root = '0;
        rt0_next.far = far1_reg;
        rt0_next.rx  = sdr_pkg::sat32({{8{vx1_reg[31]}}, vx1_reg}
                                      - {pr_x_reg[53], pr_x_reg[53:15]});
        rt0_next.ry  = sdr_pkg::sat32({{8{vy1_reg[31]}}, vy1_reg}
                                      - {{2{pr_y_reg[52]}}, pr_y_reg[52:15]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rt_reg[0] <= rt0_next;
        end
    end

    // Valid bits of all back stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg  <= 1'b0;
            rt_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg  <= q_pop;
            rt_vld_reg  <= {rt_vld_reg[sdr_pkg::ROOT_STAGES-1:0], b1_vld_reg};
            out_vld_reg <= rt_vld_reg[sdr_pkg::ROOT_STAGES];
        end
    end

    // Square root: one result bit per stage
    for (genvar k = 0; k < sdr_pkg::ROOT_STAGES; k++) begin : g_root
        logic [35:0] trial, tval;
        logic        ge;
        rt_t         stage_next;

        always_comb begin
            trial = {rt_reg[k].rem, rt_reg[k].n[63:62]};
            tval  = {2'b00, rt_reg[k].root, 2'b01};
            ge    = (trial >= tval);
            stage_next      = rt_reg[k];
            stage_next.n    = {rt_reg[k].n[61:0], 2'b00};
            if (ge) begin
                stage_next.rem  = 34'(trial - tval);
                stage_next.root = {rt_reg[k].root[30:0], 1'b1};
            end else begin
                stage_next.rem  = trial[33:0];
                stage_next.root = {rt_reg[k].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_reg[k+1] <= stage_next;
            end
        end
    end

    // Saturate the distance and hold the result
    always_ff @(posedge aclk) begin
        if (en) begin
            if (rt_reg[sdr_pkg::ROOT_STAGES].far || rt_reg[sdr_pkg::ROOT_STAGES].root[31]) begin
                dist_reg <= sdr_pkg::DIST_MAX;
            end else begin
                dist_reg <= rt_reg[sdr_pkg::ROOT_STAGES].root[30:0];
            end
            rx_reg <= rt_reg[sdr_pkg::ROOT_STAGES].rx;
            ry_reg <= rt_reg[sdr_pkg::ROOT_STAGES].ry;
        end
    end

    `SDR_ASSERT_NEXT(a_back_move, aclk, aresetn, rt_vld_reg[0] && en, rt_vld_reg[1])
    `SDR_ASSERT_NEXT(a_back_hold, aclk, aresetn, !en, $stable(rt_vld_reg))

endmodule

@@ rtl/segment_distance_and_reflection_top.sv @@
// Throughput: one item per cycle while nothing stalls; the 32-stage square root
// pipeline and the 33x18 rotation multipliers each take a new item every cycle.
// A four-entry queue lets the front keep accepting while the output is held.
// Reset (aresetn low, synchronous) empties all stages and the queue and loads
// start 0,0, cos 1.0, sin 0, length 0.
// ----------------------------------------------------------------------------
// Segment distance and reflection, top level
// Point-to-segment distance and velocity reflection for one wall segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_distance_and_reflection_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_vel_x,
    input  logic signed [31:0]   s_vel_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [30:0]          m_dist_res,
    output logic signed [31:0]   m_refl_x,
    output logic signed [31:0]   m_refl_y
);

    sdr_pkg::cfg_t    cfg_reg;
    logic             q_push, q_push_ready, q_pop, q_valid;
    sdr_pkg::q_item_t q_in, q_out;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x <= '0;
            cfg_reg.start_y <= '0;
            cfg_reg.cos_a   <= 18'sd65536;
            cfg_reg.sin_a   <= '0;
            cfg_reg.seg_len <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sdr_pkg::REG_START_X: cfg_reg.start_x <= cfg_data;
                sdr_pkg::REG_START_Y: cfg_reg.start_y <= cfg_data;
                sdr_pkg::REG_COS:     cfg_reg.cos_a   <= cfg_data[17:0];
                sdr_pkg::REG_SIN:     cfg_reg.sin_a   <= cfg_data[17:0];
                sdr_pkg::REG_LENGTH:  cfg_reg.seg_len <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    sdr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pos_x (s_pos_x),
        .s_pos_y (s_pos_y),
        .s_vel_x (s_vel_x),
        .s_vel_y (s_vel_y),
        .q_push  (q_push),
        .q_ready (q_push_ready),
        .q_item  (q_in)
    );

    sdr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out)
    );

    sdr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_out),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_dist_res (m_dist_res),
        .m_refl_x   (m_refl_x),
        .m_refl_y   (m_refl_y)
    );

endmodule

@@ sim/segment_wall_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment wall checker
// Watches the register, particle and result channels of the collision kernel.
// It keeps its own copy of the wall registers and computes the distance and
// reflected velocity of every accepted particle. Each result is then compared
// in order against the oldest computed result.
// ----------------------------------------------------------------------------

module segment_wall_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_vel_x,
    input  logic signed [31:0]  s_vel_y,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [30:0]         m_dist_res,
    input  logic signed [31:0]  m_refl_x,
    input  logic signed [31:0]  m_refl_y,
    output int                  fail_count,
    output int                  pending
);

    typedef struct {
        logic [30:0]        dist_val;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } wall_hit_t;

    localparam longint COMP_LIM = longint'(1) <<< 31;
    localparam longint S32_HI   = COMP_LIM - 1;
    localparam longint S32_LO   = -COMP_LIM;

    // Wall registers as seen by the checker
    logic signed [31:0] wall_x;
    logic signed [31:0] wall_y;
    logic signed [17:0] wall_cos;
    logic signed [17:0] wall_sin;
    logic [30:0]        wall_len;

    wall_hit_t hits_due[$];

    // Floor of the square root of a 64-bit value
    function automatic longint floor_root(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // Euclidean length of (a, b), saturating at the distance ceiling
    function automatic longint span(input longint a, input longint b);
        longint aa;
        longint bb;
        longint r;
        aa = (a < 0) ? -a : a;
        bb = (b < 0) ? -b : b;
        if (aa >= COMP_LIM || bb >= COMP_LIM) return S32_HI;
        r = floor_root(64'(aa * aa) + 64'(bb * bb));
        return (r > S32_HI) ? S32_HI : r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    // Distance to the wall and velocity mirrored about its normal
    function automatic wall_hit_t wall_response(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] vx,
                                                input logic signed [31:0] vy);
        wall_hit_t h;
        longint cs;
        longint sn;
        longint dx;
        longint dy;
        longint along;
        longint across;
        longint len;
        longint gap;
        longint dot;
        cs     = longint'(wall_cos);
        sn     = longint'(wall_sin);
        len    = longint'(wall_len);
        dx     = longint'(x) - longint'(wall_x);
        dy     = longint'(y) - longint'(wall_y);
        along  = (dx * cs + dy * sn) >>> 16;
        across = (dy * cs - dx * sn) >>> 16;
        if (along < 0) begin
            gap = span(along, across);
        end else if (along > len) begin
            gap = span(along - len, across);
        end else begin
            gap = (across < 0) ? -across : across;
            if (gap > S32_HI) gap = S32_HI;
        end
        // normal is (-sin, cos)
        dot        = (longint'(vx) * (-sn) + longint'(vy) * cs) >>> 16;
        h.dist_val = gap[30:0];
        h.rx       = 32'(clamp32(longint'(vx) - ((2 * dot * (-sn)) >>> 16)));
        h.ry       = 32'(clamp32(longint'(vy) - ((2 * dot * cs) >>> 16)));
        return h;
    endfunction

    assign pending = hits_due.size();

    always @(posedge aclk) begin
        wall_hit_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            wall_x   <= '0;
            wall_y   <= '0;
            wall_cos <= 18'sd65536;
            wall_sin <= '0;
            wall_len <= '0;
            fail_count <= 0;
            hits_due.delete();
        end else begin
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sdr_pkg::REG_START_X: wall_x   <= cfg_data;
                    sdr_pkg::REG_START_Y: wall_y   <= cfg_data;
                    sdr_pkg::REG_COS:     wall_cos <= cfg_data[17:0];
                    sdr_pkg::REG_SIN:     wall_sin <= cfg_data[17:0];
                    sdr_pkg::REG_LENGTH:  wall_len <= cfg_data[30:0];
                    default: ;
                endcase
            end
            // Compare each result with the oldest pending one
            if (m_valid && m_ready) begin
                if (hits_due.size() == 0) begin
                    $error("unexpected result item dist_res=%0d", m_dist_res);
                    errs = errs + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (m_dist_res !== want.dist_val) begin
                        $error("dist_res expected %0d actual %0d", want.dist_val, m_dist_res);
                        errs = errs + 1;
                    end
                    if (m_refl_x !== want.rx) begin
                        $error("refl_x expected %0d actual %0d", want.rx, m_refl_x);
                        errs = errs + 1;
                    end
                    if (m_refl_y !== want.ry) begin
                        $error("refl_y expected %0d actual %0d", want.ry, m_refl_y);
                        errs = errs + 1;
                    end
                end
            end
            // Count all mismatches of this edge at once
            if (errs != 0) begin
                fail_count <= fail_count + errs;
            end
            // Predict each accepted particle
            if (s_valid && s_ready) begin
                hits_due.push_back(wall_response(s_pos_x, s_pos_y, s_vel_x, s_vel_y));
            end
        end
    end

endmodule

@@ sim/tb_segment_distance_and_reflection_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment distance and reflection testbench
// Drives directed and random particles through the kernel under a range of
// wall settings, with random idling on both channels, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------

module tb_segment_distance_and_reflection_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 50;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0;
    logic signed [31:0] s_pos_y = '0;
    logic signed [31:0] s_vel_x = '0;
    logic signed [31:0] s_vel_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [30:0]        m_dist_res;
    logic signed [31:0] m_refl_x;
    logic signed [31:0] m_refl_y;

    int fail_count;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;

    segment_distance_and_reflection_top i_dut (.*);

    segment_wall_checker i_checker (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Give up at a generous limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stall in random bursts until the steady tail
    initial begin
        forever begin
            @(posedge aclk);
            if (!steady && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Send one register write; stays at the accepting edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Load the whole wall, then drop the write channel
    task automatic set_wall(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [17:0] c, input logic signed [17:0] s,
                            input logic [30:0] len);
        write_reg(sdr_pkg::REG_START_X, x);
        write_reg(sdr_pkg::REG_START_Y, y);
        write_reg(sdr_pkg::REG_COS, 32'(c));
        write_reg(sdr_pkg::REG_SIN, 32'(s));
        write_reg(sdr_pkg::REG_LENGTH, {1'b0, len});
        cfg_valid <= 1'b0;
    endtask

    // Offer one particle, maybe after a gap; stays at the accepting edge
    task automatic send_particle(input logic signed [31:0] x, input logic signed [31:0] y,
                                 input logic signed [31:0] vx, input logic signed [31:0] vy);
        if (!steady && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        s_vel_x <= vx;
        s_vel_y <= vy;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Coordinate either anywhere or close to a reference point
    function automatic logic signed [31:0] coord_near(input logic signed [31:0] ref_pt);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ref_pt + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return ref_pt + $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return ref_pt + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_speed();
        case ($urandom_range(0, 2))
            0: return $urandom;
            default: return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        endcase
    endfunction

    initial begin
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [17:0] wc;
        logic signed [17:0] ws;
        logic [30:0]        wl;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset wall: zero length at the origin, along x
        send_particle(0, 0, 0, 0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_particle(-65536, 3 << 16, 1 << 16, -(2 << 16));
        send_particle(65536, 3 << 16, -(5 << 16), 7 << 16);
        send_particle(0, -(5 << 16), 3, -3);
        drain();

        // Vertical wall of length 10 from (1, 2)
        set_wall(1 << 16, 2 << 16, 18'sd0, 18'sd65536, 31'(10 << 16));
        send_particle(3 << 16, 6 << 16, 4 << 16, 1 << 16);
        send_particle(-(4 << 16), 1 << 16, -1, 9 << 16);
        send_particle(1 << 16, 12 << 16, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_particle(9 << 16, 20 << 16, 32'h8000_0000, 32'h8000_0000);
        send_particle(1 << 16, 2 << 16, 0, 0);
        drain();

        // Unnormalized diagonal: rotation scales and reflection saturates
        set_wall(32'h8000_0000, 32'h7FFF_FFFF, -18'sd65536, -18'sd65536, 31'h7FFF_FFFF);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_particle(0, 0, 32'h4000_0000, 32'h8000_0000);
        drain();

        // Random walls, each with a batch of particles
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 2))
                0: begin wx = $urandom; wy = $urandom; end
                1: begin wx = 32'h7FFF_FFFF; wy = 32'h8000_0000; end
                default: begin
                    wx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                    wy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                end
            endcase
            case ($urandom_range(0, 5))
                0: begin wc = 18'sd65536;  ws = 18'sd0; end
                1: begin wc = -18'sd65536; ws = 18'sd65536; end
                2: begin wc = 18'sd46341;  ws = -18'sd46341; end
                3: begin wc = 18'($urandom); ws = 18'($urandom); end
                default: begin
                    wc = 18'($signed($urandom_range(0, 131072)) - 65536);
                    ws = 18'($signed($urandom_range(0, 131072)) - 65536);
                end
            endcase
            case ($urandom_range(0, 3))
                0: wl = '0;
                1: wl = 31'h7FFF_FFFF;
                2: wl = 31'($urandom);
                default: wl = 31'($urandom_range(0, 1 << 22));
            endcase
            if (phase == 9) steady = 1'b1;
            set_wall(wx, wy, wc, ws, wl);
            for (int n = 0; n < 125; n++) begin
                send_particle(coord_near(wx), coord_near(wy), rand_speed(), rand_speed());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sdr_pkg.sv
rtl/sdr_front.sv
rtl/sdr_fifo.sv
rtl/sdr_back.sv
rtl/segment_distance_and_reflection_top.sv
sim/segment_wall_checker.sv
sim/tb_segment_distance_and_reflection_top.sv
